@@ design/uics_pkg.sv @@
// Shared types and byte constants for the UTF-8 invisible code point stripper.
// No dependencies; imported by every module of the block.
package uics_pkg;

	localparam logic [7:0] ByteEf      = 8'hEF;
	localparam logic [7:0] ByteBf      = 8'hBF;
	localparam logic [7:0] ByteBc      = 8'hBC;
	localparam logic [7:0] ByteE2      = 8'hE2;
	localparam logic [7:0] Byte80      = 8'h80;
	localparam logic [7:0] ByteAe      = 8'hAE;
	localparam logic [7:0] Byte8b      = 8'h8B;
	localparam logic [7:0] Byte8d      = 8'h8D;
	localparam logic [7:0] Lead4Low    = 8'hF0;
	localparam logic [7:0] Lead4High   = 8'hF7;
	localparam logic [7:0] ContMask    = 8'hC0;
	localparam logic [7:0] ContPattern = 8'h80;

	localparam int WinDepth     = 4;
	localparam int FifoDepthDef = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} msg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_message;
		logic       was_changed;
	} res_t;

	function automatic logic is_lead4(input logic [7:0] b);
		return (b >= Lead4Low) && (b <= Lead4High);
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return (b & ContMask) == ContPattern;
	endfunction

endpackage

@@ design/uics_front.sv @@
// Front end: accepts bytes, holds the lookahead window and decides drop/keep.
// Pushes kept bytes and the end marker into the queue. Depends on uics_pkg.
module uics_front import uics_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic msg_valid,
	output logic msg_stall,
	input  msg_t msg,
	output logic push,
	output res_t push_data,
	input  logic full
);

	logic [7:0] win_q [WinDepth];
	logic [7:0] win_d [WinDepth];
	logic [2:0] cnt_q;
	logic       flush_q;
	logic       prev4_q;
	logic       dropped_q;

	logic [7:0] v [WinDepth];
	logic [2:0] n;
	logic       accept;
	logic       do_step;
	logic       drop;
	logic       emit;
	logic       end_push;
	logic       hdr_efbfbc;
	logic       hdr_e280;
	logic       fwd;

	assign msg_stall = flush_q || full;
	assign accept    = msg_valid && !msg_stall;

	always_comb begin
		v       = win_q;
		n       = cnt_q;
		do_step = 1'b0;
		if (!flush_q) begin
			if (accept && !msg.in_last && cnt_q == 3'd3) begin
				v[3]    = msg.in_byte;
				n       = 3'd4;
				do_step = 1'b1;
			end
		end else if (!full && cnt_q != 3'd0) begin
			do_step = 1'b1;
		end
	end

	// Pattern match on the head of the window
	always_comb begin
		hdr_efbfbc = (v[0] == ByteEf) && (v[1] == ByteBf) && (v[2] == ByteBc);
		hdr_e280   = (v[0] == ByteE2) && (v[1] == Byte80);
		fwd        = (n == 3'd4) && is_lead4(v[3]);
		drop       = (n >= 3'd3) && (hdr_efbfbc || (hdr_e280 &&
			((v[2] == ByteAe) || (v[2] == Byte8b) ||
			((v[2] == Byte8d) && !(fwd && prev4_q)))));
	end

	assign emit     = do_step && !drop;
	assign end_push = flush_q && !full && cnt_q == 3'd0;
	assign push     = emit || end_push;

	always_comb begin
		if (emit) begin
			push_data = '{out_byte: v[0], byte_valid: 1'b1,
				end_of_message: 1'b0, was_changed: 1'b0};
		end else begin
			push_data = '{out_byte: 8'h00, byte_valid: 1'b0,
				end_of_message: 1'b1, was_changed: dropped_q};
		end
	end

	always_comb begin
		win_d = win_q;
		if (do_step) begin
			if (drop) begin
				win_d[0] = v[3];
			end else begin
				win_d[0] = v[1];
				win_d[1] = v[2];
				win_d[2] = v[3];
			end
		end else if (!flush_q && accept) begin
			win_d[cnt_q[1:0]] = msg.in_byte;
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= 3'd0;
			flush_q   <= 1'b0;
			prev4_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else if (do_step) begin
			if (drop) begin
				cnt_q     <= n - 3'd3;
				prev4_q   <= 1'b0;
				dropped_q <= 1'b1;
			end else begin
				cnt_q <= n - 3'd1;
				if (!is_cont(v[0])) begin
					prev4_q <= is_lead4(v[0]);
				end
			end
		end else if (end_push) begin
			flush_q   <= 1'b0;
			prev4_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else if (!flush_q && accept) begin
			cnt_q <= cnt_q + 3'd1;
			if (msg.in_last) begin
				flush_q <= 1'b1;
			end
		end
	end

endmodule

@@ design/uics_fifo.sv @@
// Short result queue between the front end and the output stage.
// Depends on uics_pkg for the result type.
module uics_fifo import uics_pkg::*; #(
	parameter int Depth = FifoDepthDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output res_t head
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	res_t            mem [Depth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full     = cnt_q == FullCnt;
	assign nonempty = cnt_q != '0;
	assign head     = mem[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ design/uics_out.sv @@
// Output stage: registered result channel fed from the queue.
// Depends on uics_pkg for the result type.
module uics_out import uics_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic nonempty,
	input  res_t head,
	output logic pop,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic valid_q;
	res_t data_q;

	assign pop       = nonempty && (!valid_q || !res_stall);
	assign res_valid = valid_q;
	assign res       = data_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

@@ design/utf8_invisible_codepoint_stripper_core.sv @@
// Top level of the UTF-8 invisible code point stripper.
// Instantiates uics_front, uics_fifo and uics_out; depends on uics_pkg.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  msg     | in  | msg_valid/msg_stall  | msg_t: in_byte, in_last
//  res     | out | res_valid/res_stall  | res_t: out_byte, byte_valid,
//          |     |                      |        end_of_message, was_changed
//
// One byte is taken per cycle in mid-message while the queue is not full; a kept
// byte enters the queue when the byte that pushes it out of the three-byte window
// is taken, and reaches res through the output register. The transaction with
// in_last set starts a flush in the front end, which steps out each window byte
// or dropped sequence and then pushes the end marker; msg_stall is high meanwhile.
// Reset (arst_n low) empties window, queue and output register at once.
// res_stall backs up through the output register into the queue; msg_stall
// rises only when the queue is full or a flush is running.
module utf8_invisible_codepoint_stripper_core import uics_pkg::*; #(
	parameter int FifoDepth = FifoDepthDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic msg_valid,
	output logic msg_stall,
	input  msg_t msg,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic push;
	res_t push_data;
	logic full;
	logic pop;
	logic nonempty;
	res_t head;

	// Front end: window, pattern match, joiner neighbor check, flush
	uics_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// Decoupling queue; absorbs the flush burst at message end
	uics_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.nonempty  (nonempty),
		.head      (head)
	);

	// Back end: registered output transaction
	uics_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.nonempty  (nonempty),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

@@ sim/utf8_invisible_codepoint_stripper_core_tb.sv @@
// Self-checking testbench for utf8_invisible_codepoint_stripper_core.
// Keeps its own model of the byte window to predict kept bytes and end markers;
// depends on uics_pkg and the block's RTL.
`timescale 1ns / 100ps

module utf8_invisible_codepoint_stripper_core_tb;
	import uics_pkg::*;

	localparam int StuckLimit   = 3000; // cycles without any transaction
	localparam int MaxPrinted   = 100;
	localparam int HoldCycles   = 300;
	localparam int PhaseBytes   = 8;
	localparam int HoldBytes    = 16;
	localparam int TailCycles   = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic msg_valid = 1'b0;
	logic msg_stall;
	msg_t msg = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	utf8_invisible_codepoint_stripper_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction: lookahead window of the byte stream, same decisions as
	// the block makes on the byte leaving the window head.
	// ------------------------------------------------------------------
	logic [7:0] window [4];
	int         win_fill = 0;
	logic       prev_lead4 = 1'b0;   // last non-continuation byte out was F0..F7
	logic       msg_dropped = 1'b0;  // something removed in this message
	res_t       expected_res [$];

	function void window_shift(input int n);
		for (int i = 0; i + n < 4; i++)
			window[i] = window[i + n];
		win_fill -= n;
	endfunction

	// Either drop a whole 3-byte sequence at the head or pass one byte on.
	function void resolve_head();
		logic drop;
		logic fwd_lead4;
		drop = 1'b0;
		if (win_fill >= 3) begin
			if (window[0] == ByteEf && window[1] == ByteBf && window[2] == ByteBc) begin
				drop = 1'b1;
			end else if (window[0] == ByteE2 && window[1] == Byte80) begin
				if (window[2] == ByteAe || window[2] == Byte8b) begin
					drop = 1'b1;
				end else if (window[2] == Byte8d) begin
					// joiner survives only between two 4-byte leads
					fwd_lead4 = (win_fill == 4) && window[3] >= Lead4Low &&
						window[3] <= Lead4High;
					drop = !(fwd_lead4 && prev_lead4);
				end
			end
		end
		if (drop) begin
			window_shift(3);
			prev_lead4 = 1'b0;  // the dropped lead (E2/EF) is not a 4-byte lead
			msg_dropped = 1'b1;
		end else begin
			if ((window[0] & ContMask) != ContPattern)
				prev_lead4 = window[0] >= Lead4Low && window[0] <= Lead4High;
			expected_res.push_back('{out_byte: window[0], byte_valid: 1'b1,
				end_of_message: 1'b0, was_changed: 1'b0});
			window_shift(1);
		end
	endfunction

	function void predict_stripped(input logic [7:0] b, input logic last);
		window[win_fill] = b;
		win_fill++;
		while (win_fill == 4 || (last && win_fill > 0))
			resolve_head();
		if (last) begin
			expected_res.push_back('{out_byte: 8'h00, byte_valid: 1'b0,
				end_of_message: 1'b1, was_changed: msg_dropped});
			win_fill = 0;
			prev_lead4 = 1'b0;
			msg_dropped = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	int errors = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < MaxPrinted)
			$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
				$time, what, got, want);
		errors++;
	endtask

	task automatic check_result(input res_t got);
		res_t want;
		if (expected_res.size() == 0) begin
			report_mismatch("unexpected result transaction", int'(got), 0);
		end else begin
			want = expected_res.pop_front();
			if (got.out_byte !== want.out_byte)
				report_mismatch("out_byte", int'(got.out_byte), int'(want.out_byte));
			if (got.byte_valid !== want.byte_valid)
				report_mismatch("byte_valid", int'(got.byte_valid),
					int'(want.byte_valid));
			if (got.end_of_message !== want.end_of_message)
				report_mismatch("end_of_message", int'(got.end_of_message),
					int'(want.end_of_message));
			if (got.was_changed !== want.was_changed)
				report_mismatch("was_changed", int'(got.was_changed),
					int'(want.was_changed));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			check_result(res);
	end

	// ------------------------------------------------------------------
	// Receiver: random stalls, or a long hold-off counted down here.
	// ------------------------------------------------------------------
	int recv_stall_pct = 0;
	int send_idle_pct = 0;
	int hold_left = 0;

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: ends the run if no transaction moves for too long.
	int stuck_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((msg_valid && !msg_stall) || (res_valid && !res_stall)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= StuckLimit) begin
				$display("utf8_invisible_codepoint_stripper_core_tb failed");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------
	logic [7:0] msg_buf [$];
	int bytes_sent = 0;

	// Called at a rising edge; returns at the edge where the byte was taken,
	// with valid still high so back-to-back transactions need no gap.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			msg_valid <= 1'b0;
			@(posedge clk);
		end
		msg_valid <= 1'b1;
		msg <= '{in_byte: b, in_last: last};
		do @(posedge clk); while (msg_stall);
		predict_stripped(b, last);
		bytes_sent++;
	endtask

	// Sends msg_buf as one message; before byte pause_at the sender drops
	// valid and waits until every result expected so far has come out.
	task automatic send_msg(input int pause_at);
		for (int i = 0; i < msg_buf.size(); i++) begin
			if (i == pause_at) begin
				msg_valid <= 1'b0;
				do @(posedge clk); while (expected_res.size() != 0);
			end
			send_byte(msg_buf[i], i == msg_buf.size() - 1);
		end
	endtask

	function automatic logic [7:0] cont_byte();
		return ContPattern | 8'($urandom_range(63));
	endfunction

	// Random message made of pieces that hit the matcher often: the removed
	// sequences, joiners between emoji, near-misses and raw noise.
	function automatic void build_random_msg();
		int len;
		len = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 10);
		msg_buf.delete();
		while (msg_buf.size() < len) begin
			case ($urandom_range(10))
				0: msg_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
				1: msg_buf.push_back(8'($urandom_range(255)));
				2: begin
					msg_buf.push_back(ByteEf); msg_buf.push_back(ByteBf);
					msg_buf.push_back(ByteBc);
				end
				3: begin
					msg_buf.push_back(ByteE2); msg_buf.push_back(Byte80);
					msg_buf.push_back($urandom_range(1) ? ByteAe : Byte8b);
				end
				4, 5: begin
					msg_buf.push_back(ByteE2); msg_buf.push_back(Byte80);
					msg_buf.push_back(Byte8d);
				end
				6: begin
					msg_buf.push_back(Lead4Low + 8'($urandom_range(7)));
					repeat (3) msg_buf.push_back(cont_byte());
				end
				7: begin
					// emoji, joiner, emoji: the joiner is kept
					msg_buf.push_back(Lead4Low + 8'($urandom_range(7)));
					repeat (3) msg_buf.push_back(cont_byte());
					msg_buf.push_back(ByteE2); msg_buf.push_back(Byte80);
					msg_buf.push_back(Byte8d);
					msg_buf.push_back(Lead4Low + 8'($urandom_range(7)));
					repeat (3) msg_buf.push_back(cont_byte());
				end
				8: begin
					// near miss: right prefix, random third byte
					if ($urandom_range(1)) begin
						msg_buf.push_back(ByteE2); msg_buf.push_back(Byte80);
					end else begin
						msg_buf.push_back(ByteEf); msg_buf.push_back(ByteBf);
					end
					msg_buf.push_back(8'($urandom_range(255)));
				end
				9: msg_buf.push_back(cont_byte());
				default: msg_buf.push_back(8'($urandom_range(8'hF8, 8'hFF)));
			endcase
		end
	endfunction

	task automatic send_random_bytes(input int n);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n) begin
			build_random_msg();
			send_msg(-1);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// object replacement char alone: dropped, changed flag set
		msg_buf = '{8'hEF, 8'hBF, 8'hBC};
		send_msg(-1);
		// joiner after F0 (continuations skipped backward) and before F7: kept
		msg_buf = '{8'hF0, 8'h80, 8'hE2, 8'h80, 8'h8D, 8'hF7};
		send_msg(-1);
		// RTL override, zero-width space, then a joiner ending the message
		msg_buf = '{8'hE2, 8'h80, 8'hAE, 8'hE2, 8'h80, 8'h8B, 8'hE2, 8'h80, 8'h8D};
		send_msg(-1);
		// match starting one byte late; joiner after a plain E2 lead is dropped
		msg_buf = '{8'hE2, 8'hE2, 8'h80, 8'h8D, 8'hF0};
		send_msg(-1);
		// byte extremes and a short tail that never matches
		msg_buf = '{8'h00, 8'hFF, 8'hE2, 8'h80};
		send_msg(-1);
	endtask

	task automatic test_no_idle();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_random_bytes(PhaseBytes);
	endtask

	task automatic test_sender_idle();
		send_idle_pct = 66;
		recv_stall_pct = 0;
		send_random_bytes(PhaseBytes);
	endtask

	task automatic test_receiver_stall();
		send_idle_pct = 0;
		recv_stall_pct = 66;
		send_random_bytes(PhaseBytes);
	endtask

	task automatic test_both_idle();
		send_idle_pct = 34;
		recv_stall_pct = 34;
		send_random_bytes(PhaseBytes);
	endtask

	// Receiver holds off while the sender keeps offering bytes, so the
	// queue fills and msg_stall must back up.
	task automatic test_output_hold();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = HoldCycles;
		send_random_bytes(HoldBytes);
	endtask

	// Sender stops mid-message until everything predicted has come out.
	task automatic test_sender_pause();
		send_idle_pct = 10;
		recv_stall_pct = 50;
		repeat (2) begin
			do build_random_msg(); while (msg_buf.size() < 6);
			send_msg(msg_buf.size() / 2);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_output_hold();
		test_sender_pause();
		// every message ended with a last byte, so all results are predicted
		msg_valid <= 1'b0;
		recv_stall_pct = 0;
		do @(posedge clk); while (expected_res.size() != 0);
		repeat (TailCycles) @(posedge clk);
		if (errors == 0)
			$display("utf8_invisible_codepoint_stripper_core_tb passed");
		else
			$display("utf8_invisible_codepoint_stripper_core_tb failed");
		$finish;
	end

endmodule

@@ files.f @@
design/uics_pkg.sv
design/uics_front.sv
design/uics_fifo.sv
design/uics_out.sv
design/utf8_invisible_codepoint_stripper_core.sv
sim/utf8_invisible_codepoint_stripper_core_tb.sv
